// ===== rtl/core/thr_pkg.sv =====
package thr_pkg;

    // Ring geometry.
    localparam int DEPTH = 128;
    localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths of a command word and a result word.
    localparam int CMD_W = 2;
    localparam int OBJ_W = 32;
    localparam int PAY_W = 64;
    localparam int FRM_W = 32;
    localparam int AGE_W = 7;
    localparam int HC_W  = 8;

    // Common width for comparing an age against the held count.
    localparam int CMP_W = (AGE_W > CNT_W) ? AGE_W : CNT_W;

    // Command queue between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_EXPIRE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } thr_cmd_t;

    // One command word as it travels through the queue.
    typedef struct packed {
        thr_cmd_t         command;
        logic [OBJ_W-1:0] object_handle;
        logic [PAY_W-1:0] payload;
        logic [FRM_W-1:0] frame_stamp;
        logic [AGE_W-1:0] age;
    } thr_item_t;

    // One ring entry as stored in memory.
    typedef struct packed {
        logic [OBJ_W-1:0] object_handle;
        logic [PAY_W-1:0] payload;
        logic [FRM_W-1:0] frame_stamp;
    } thr_entry_t;

    localparam int ENTRY_W = $bits(thr_entry_t);

    // Next ring position, with wrap.
    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] res;
        if (pos == POS_W'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = pos + POS_W'(1);
        end
        return res;
    endfunction

    // Previous ring position, with wrap.
    function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] res;
        if (pos == '0)
        begin
            res = POS_W'(DEPTH - 1);
        end
        else
        begin
            res = pos - POS_W'(1);
        end
        return res;
    endfunction

    // Slot that lies back pushes behind newest; back is below DEPTH.
    function automatic logic [POS_W-1:0] pos_back(input logic [POS_W-1:0] newest,
                                                  input logic [POS_W-1:0] back);
        logic [POS_W:0] sum;
        if (back > newest)
        begin
            sum = {1'b0, newest} + (POS_W+1)'(DEPTH) - {1'b0, back};
        end
        else
        begin
            sum = {1'b0, newest} - {1'b0, back};
        end
        return sum[POS_W-1:0];
    endfunction

    // True when an age addresses a held entry.
    function automatic logic age_held(input logic [AGE_W-1:0] age,
                                      input logic [CNT_W-1:0] count);
        return CMP_W'(age) < CMP_W'(count);
    endfunction

    // Age reduced to a ring offset; only meaningful when the age is held.
    function automatic logic [POS_W-1:0] age_pos(input logic [AGE_W-1:0] age);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(age);
        return wide[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/core/thr_ram.sv =====
module thr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== rtl/core/thr_front.sv =====
module thr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [thr_pkg::CMD_W-1:0] command,
    input  logic [thr_pkg::OBJ_W-1:0] object_handle,
    input  logic [thr_pkg::PAY_W-1:0] payload,
    input  logic [thr_pkg::FRM_W-1:0] frame_stamp,
    input  logic [thr_pkg::AGE_W-1:0] age,
    output logic                      item_valid,
    output thr_pkg::thr_item_t        item,
    input  logic                      item_pop
);

    import thr_pkg::*;

    thr_item_t         q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] q_cnt_reg;
    logic [QCNT_W-1:0] q_cnt_next;
    logic              accept;
    logic              take;
    thr_item_t         in_word;

    // Decode the command word into its typed form.
    always_comb
    begin
        in_word.command       = thr_cmd_t'(command);
        in_word.object_handle = object_handle;
        in_word.payload       = payload;
        in_word.frame_stamp   = frame_stamp;
        in_word.age           = age;
    end

    // The front holds off only when the queue is full.
    assign busy       = (q_cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept     = start && !busy;
    assign item_valid = (q_cnt_reg != '0);
    assign take       = item_pop && item_valid;
    assign item       = q_reg[rd_ptr_reg];

    // Queue pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (take)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (accept && !take)
        begin
            q_cnt_next = q_cnt_reg + QCNT_W'(1);
        end
        else if (take && !accept)
        begin
            q_cnt_next = q_cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

// ===== rtl/core/thr_back.sv =====
module thr_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  thr_pkg::thr_item_t        item,
    output logic                      item_pop,
    output logic                      done,
    output logic                      hit,
    output logic [thr_pkg::OBJ_W-1:0] out_object,
    output logic [thr_pkg::PAY_W-1:0] out_payload,
    output logic [thr_pkg::FRM_W-1:0] out_frame,
    output logic [thr_pkg::HC_W-1:0]  held_count
);

    import thr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_WALK = 3'b100
    } thr_state_t;

    thr_state_t       state_reg;
    thr_state_t       state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [POS_W-1:0] walk_reg;
    logic [POS_W-1:0] walk_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [FRM_W-1:0] thr_reg;
    logic [FRM_W-1:0] thr_next;
    logic             done_reg;
    logic             done_next;
    logic             hit_reg;
    logic             hit_next;
    logic [OBJ_W-1:0] obj_reg;
    logic [OBJ_W-1:0] obj_next;
    logic [PAY_W-1:0] pay_reg;
    logic [PAY_W-1:0] pay_next;
    logic [FRM_W-1:0] frm_reg;
    logic [FRM_W-1:0] frm_next;
    logic [HC_W-1:0]  hc_reg;
    logic [HC_W-1:0]  hc_next;

    logic               ram_we;
    logic [POS_W-1:0]   ram_waddr;
    thr_entry_t         ram_wentry;
    logic               ram_re;
    logic [POS_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    thr_entry_t         rd_entry;
    logic [CNT_W-1:0]   idx_inc;

    assign rd_entry = thr_entry_t'(ram_rdata);
    assign idx_inc  = idx_reg + CNT_W'(1);

    always_comb
    begin
        ram_wentry.object_handle = item.object_handle;
        ram_wentry.payload       = item.payload;
        ram_wentry.frame_stamp   = item.frame_stamp;
    end

    thr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wentry),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Command sequencer: one memory access per cycle, the expire walk one entry a cycle.
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        walk_next  = walk_reg;
        idx_next   = idx_reg;
        thr_next   = thr_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        obj_next   = obj_reg;
        pay_next   = pay_reg;
        frm_next   = frm_reg;
        hc_next    = hc_reg;
        item_pop   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = pos_inc(pos_reg);
        ram_re     = 1'b0;
        ram_raddr  = walk_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    // Results other than a read hit carry zero data fields.
                    hit_next = 1'b0;
                    obj_next = '0;
                    pay_next = '0;
                    frm_next = '0;
                    case (item.command)
                        CMD_PUSH:
                        begin
                            pos_next = pos_inc(pos_reg);
                            ram_we   = 1'b1;
                            if (count_reg != CNT_W'(DEPTH))
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            hc_next   = HC_W'(count_next);
                            done_next = 1'b1;
                        end
                        CMD_EXPIRE:
                        begin
                            if (count_reg == '0)
                            begin
                                hc_next   = '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = pos_reg;
                                walk_next  = pos_dec(pos_reg);
                                idx_next   = '0;
                                thr_next   = item.frame_stamp;
                                state_next = ST_WALK;
                            end
                        end
                        CMD_READ:
                        begin
                            if (age_held(item.age, count_reg))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = pos_back(pos_reg, age_pos(item.age));
                                state_next = ST_READ;
                            end
                            else
                            begin
                                hc_next   = HC_W'(count_reg);
                                done_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            pos_next   = POS_W'(DEPTH - 1);
                            count_next = '0;
                            hc_next    = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                hit_next   = 1'b1;
                obj_next   = rd_entry.object_handle;
                pay_next   = rd_entry.payload;
                frm_next   = rd_entry.frame_stamp;
                hc_next    = HC_W'(count_reg);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (rd_entry.frame_stamp >= thr_reg)
                begin
                    if (idx_inc == count_reg)
                    begin
                        // Every held entry meets the threshold.
                        hc_next    = HC_W'(count_reg);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = walk_reg;
                        walk_next = pos_dec(walk_reg);
                        idx_next  = idx_inc;
                    end
                end
                else
                begin
                    // First older entry stops the walk.
                    count_next = idx_reg;
                    hc_next    = HC_W'(idx_reg);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= POS_W'(DEPTH - 1);
            count_reg <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            hc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            hc_reg    <= hc_next;
        end
    end

    // Walk and result data registers need no reset.
    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
        idx_reg  <= idx_next;
        thr_reg  <= thr_next;
        obj_reg  <= obj_next;
        pay_reg  <= pay_next;
        frm_reg  <= frm_next;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign out_object  = obj_reg;
    assign out_payload = pay_reg;
    assign out_frame   = frm_reg;
    assign held_count  = hc_reg;

endmodule

// ===== rtl/core/timestamped_history_ring_core.sv =====
// From accepted start to done, a word passes the command queue, then the back end, which
// registers the result; a read hit also passes ST_READ and a walking expire ST_WALK.
// Back end takes one word per cycle for push, clear, miss and empty expire, none in
// ST_READ or ST_WALK; a 2-word command queue sets when busy rises.
// The receiver cannot stall: each result word shows on done for exactly one cycle.
// Asynchronous active-low reset empties the queue and the ring; memory is not cleared.
module timestamped_history_ring_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [thr_pkg::CMD_W-1:0] command,
    input  logic [thr_pkg::OBJ_W-1:0] object_handle,
    input  logic [thr_pkg::PAY_W-1:0] payload,
    input  logic [thr_pkg::FRM_W-1:0] frame_stamp,
    input  logic [thr_pkg::AGE_W-1:0] age,
    output logic                      done,
    output logic                      hit,
    output logic [thr_pkg::OBJ_W-1:0] out_object,
    output logic [thr_pkg::PAY_W-1:0] out_payload,
    output logic [thr_pkg::FRM_W-1:0] out_frame,
    output logic [thr_pkg::HC_W-1:0]  held_count
);

    import thr_pkg::*;

    logic      item_valid;
    logic      item_pop;
    thr_item_t item;

    // Front: accepts and decodes command words into the queue.
    thr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .object_handle (object_handle),
        .payload       (payload),
        .frame_stamp   (frame_stamp),
        .age           (age),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    // Back: carries out each command against the ring memory.
    thr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop),
        .done        (done),
        .hit         (hit),
        .out_object  (out_object),
        .out_payload (out_payload),
        .out_frame   (out_frame),
        .held_count  (held_count)
    );

endmodule

// ===== rtl/core/thr_checker.sv =====
module thr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      done,
    input logic                      hit,
    input logic [thr_pkg::OBJ_W-1:0] out_object,
    input logic [thr_pkg::PAY_W-1:0] out_payload,
    input logic [thr_pkg::FRM_W-1:0] out_frame,
    input logic [thr_pkg::HC_W-1:0]  held_count
);

    import thr_pkg::*;

    // The reported count never exceeds the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (CNT_W'(held_count) <= CNT_W'(DEPTH)))
    else $error("held_count beyond ring depth");

    // A word without a hit carries zero data fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (out_object == '0 && out_payload == '0 && out_frame == '0))
    else $error("nonzero data on a result word without hit");

    // A hit is only possible while entries are held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (held_count != '0))
    else $error("hit reported with an empty ring");

    // The count shown changes only together with a result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(held_count) |-> done)
    else $error("held_count changed without a result word");

endmodule

bind timestamped_history_ring_core thr_checker u_thr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .done        (done),
    .hit         (hit),
    .out_object  (out_object),
    .out_payload (out_payload),
    .out_frame   (out_frame),
    .held_count  (held_count)
);

// ===== test/timestamped_history_ring_core_test.sv =====
module timestamped_history_ring_core_test;
    import thr_pkg::*;

    localparam int WORD_TARGET  = 2000;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    // One result word as the block presents it.
    typedef struct packed {
        logic             hit;
        logic [OBJ_W-1:0] object_handle;
        logic [PAY_W-1:0] payload;
        logic [FRM_W-1:0] frame_stamp;
        logic [HC_W-1:0]  held_count;
    } ring_view_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             start         = 1'b0;
    logic [CMD_W-1:0] command       = '0;
    logic [OBJ_W-1:0] object_handle = '0;
    logic [PAY_W-1:0] payload       = '0;
    logic [FRM_W-1:0] frame_stamp   = '0;
    logic [AGE_W-1:0] age           = '0;
    logic             busy;
    logic             done;
    logic             hit;
    logic [OBJ_W-1:0] out_object;
    logic [PAY_W-1:0] out_payload;
    logic [FRM_W-1:0] out_frame;
    logic [HC_W-1:0]  held_count;

    // Command words still to be issued, and answers owed by the block.
    thr_item_t  word_backlog[$];
    ring_view_t owed_answers[$];
    thr_item_t  issue_word;
    bit         hold_off;

    // Mirror of the ring contents and pointers.
    logic [OBJ_W-1:0] obj_mirror [DEPTH];
    logic [PAY_W-1:0] pay_mirror [DEPTH];
    logic [FRM_W-1:0] frm_mirror [DEPTH];
    int               mirror_newest;
    int               mirror_count;

    // Run bookkeeping.
    int words_total;
    int words_taken;
    int answers_seen;
    int bad_words;
    int stall_cycles;
    int n_push;
    int n_push_full;
    int n_expire;
    int n_clear;
    int n_hit;
    int n_miss;

    timestamped_history_ring_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .object_handle (object_handle),
        .payload       (payload),
        .frame_stamp   (frame_stamp),
        .age           (age),
        .done          (done),
        .hit           (hit),
        .out_object    (out_object),
        .out_payload   (out_payload),
        .out_frame     (out_frame),
        .held_count    (held_count)
    );

    always #5 clk = ~clk;

    // Apply one command word to the mirror and return the answer it produces.
    function automatic ring_view_t ring_apply(input thr_item_t w);
        ring_view_t v;
        int         walk;
        int         slot;
        v = '0;
        case (w.command)
            CMD_PUSH:
            begin
                n_push++;
                if (mirror_count == DEPTH)
                begin
                    n_push_full++;
                end
                mirror_newest = (mirror_newest + 1) % DEPTH;
                if (mirror_count < DEPTH)
                begin
                    mirror_count++;
                end
                obj_mirror[mirror_newest] = w.object_handle;
                pay_mirror[mirror_newest] = w.payload;
                frm_mirror[mirror_newest] = w.frame_stamp;
            end
            CMD_EXPIRE:
            begin
                // Keep the newest run of entries at or above the threshold.
                n_expire++;
                walk = 0;
                while (walk < mirror_count &&
                       frm_mirror[(mirror_newest + DEPTH - walk) % DEPTH] >= w.frame_stamp)
                begin
                    walk++;
                end
                mirror_count = walk;
            end
            CMD_READ:
            begin
                if (int'(w.age) < mirror_count)
                begin
                    n_hit++;
                    slot            = (mirror_newest + DEPTH - int'(w.age)) % DEPTH;
                    v.hit           = 1'b1;
                    v.object_handle = obj_mirror[slot];
                    v.payload       = pay_mirror[slot];
                    v.frame_stamp   = frm_mirror[slot];
                end
                else
                begin
                    n_miss++;
                end
            end
            default:
            begin
                n_clear++;
                mirror_newest = DEPTH - 1;
                mirror_count  = 0;
            end
        endcase
        v.held_count = HC_W'(mirror_count);
        return v;
    endfunction

    function automatic void add_word(input thr_cmd_t c, input logic [OBJ_W-1:0] o,
                                     input logic [PAY_W-1:0] p, input logic [FRM_W-1:0] f,
                                     input logic [AGE_W-1:0] a);
        thr_item_t w;
        w.command       = c;
        w.object_handle = o;
        w.payload       = p;
        w.frame_stamp   = f;
        w.age           = a;
        word_backlog.push_back(w);
    endfunction

    // Driver: a held word stays on the ports until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start         <= 1'b0;
            command       <= '0;
            object_handle <= '0;
            payload       <= '0;
            frame_stamp   <= '0;
            age           <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                owed_answers.push_back(ring_apply(issue_word));
                words_taken++;
            end
            hold_off = (words_taken < 700 || words_taken >= 1100) &&
                       ($urandom_range(0, 99) < 7);
            if (!(start && busy))
            begin
                if (word_backlog.size() != 0 && !hold_off)
                begin
                    issue_word    = word_backlog.pop_front();
                    start         <= 1'b1;
                    command       <= issue_word.command;
                    object_handle <= issue_word.object_handle;
                    payload       <= issue_word.payload;
                    frame_stamp   <= issue_word.frame_stamp;
                    age           <= issue_word.age;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done pulse must match the oldest owed answer.
    always @(posedge clk)
    begin
        ring_view_t got;
        ring_view_t want;
        if (rst_n && done)
        begin
            answers_seen++;
            got = {hit, out_object, out_payload, out_frame, held_count};
            if (owed_answers.size() == 0)
            begin
                bad_words++;
                if (bad_words <= REPORT_MAX)
                begin
                    $display("unexpected result word: hit=%0b obj=%h pay=%h frm=%h count=%0d",
                             got.hit, got.object_handle, got.payload, got.frame_stamp,
                             got.held_count);
                end
            end
            else
            begin
                want = owed_answers.pop_front();
                if (got !== want)
                begin
                    bad_words++;
                    if (bad_words <= REPORT_MAX)
                    begin
                        $display("result word %0d mismatch:", answers_seen);
                        $display("  hit   exp %0b got %0b", want.hit, got.hit);
                        $display("  obj   exp %h got %h", want.object_handle, got.object_handle);
                        $display("  pay   exp %h got %h", want.payload, got.payload);
                        $display("  frm   exp %h got %h", want.frame_stamp, got.frame_stamp);
                        $display("  count exp %0d got %0d", want.held_count, got.held_count);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any word moving either way ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int               gen_count;
        logic [FRM_W-1:0] gen_frame;
        logic [FRM_W-1:0] thr;
        int               pick;
        int               run;
        int               sub;

        mirror_newest = DEPTH - 1;
        mirror_count  = 0;

        // Directed: empty ring, field extremes, expire stopping early, clear.
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd0);
        add_word(CMD_EXPIRE, $urandom, {$urandom, $urandom}, 32'd0, 7'($urandom));
        add_word(CMD_PUSH,   '1, '1, '1, 7'($urandom));
        add_word(CMD_PUSH,   '0, '0, '0, 7'($urandom));
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd0);
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd1);
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd2);
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd127);
        add_word(CMD_PUSH,   32'h1234_5678, 64'ha5a5_a5a5_5a5a_5a5a, 32'h10, '0);
        add_word(CMD_PUSH,   32'h8765_4321, 64'h5a5a_5a5a_a5a5_a5a5, 32'h20, '1);
        add_word(CMD_PUSH,   32'hdead_beef, 64'h0123_4567_89ab_cdef, 32'h30, '0);
        // Walk keeps 0x30, 0x20, 0x10 and stops at 0, though all-ones lies beyond.
        add_word(CMD_EXPIRE, $urandom, {$urandom, $urandom}, 32'h10, 7'($urandom));
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd2);
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd3);
        add_word(CMD_EXPIRE, $urandom, {$urandom, $urandom}, '1, 7'($urandom));
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd0);
        add_word(CMD_PUSH,   $urandom, {$urandom, $urandom}, 32'd7, 7'($urandom));
        add_word(CMD_EXPIRE, $urandom, {$urandom, $urandom}, 32'd0, 7'($urandom));
        add_word(CMD_CLEAR,  $urandom, {$urandom, $urandom}, $urandom, 7'($urandom));
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd0);
        add_word(CMD_PUSH,   $urandom, {$urandom, $urandom}, $urandom, 7'($urandom));
        add_word(CMD_READ,   $urandom, {$urandom, $urandom}, $urandom, 7'd0);

        // Fill past capacity once, then read the oldest and newest slots.
        gen_frame = $urandom;
        gen_count = DEPTH;
        for (int k = 0; k < DEPTH + 3; k++)
        begin
            gen_frame += 32'($urandom_range(0, 3));
            add_word(CMD_PUSH, $urandom, {$urandom, $urandom}, gen_frame, 7'($urandom));
        end
        add_word(CMD_READ, $urandom, {$urandom, $urandom}, $urandom, 7'd127);
        add_word(CMD_READ, $urandom, {$urandom, $urandom}, $urandom, 7'd126);
        add_word(CMD_READ, $urandom, {$urandom, $urandom}, $urandom, 7'd0);

        // Random traffic: mostly push runs with rising frames, reads and expires.
        while (word_backlog.size() < WORD_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                run = ($urandom_range(0, 199) < 3) ? $urandom_range(128, 140)
                                                   : $urandom_range(1, 12);
                for (int k = 0; k < run; k++)
                begin
                    gen_frame += 32'($urandom_range(0, 3));
                    add_word(CMD_PUSH, $urandom, {$urandom, $urandom},
                             ($urandom_range(0, 19) == 0) ? 32'($urandom) : gen_frame,
                             7'($urandom));
                    if (gen_count < DEPTH)
                    begin
                        gen_count++;
                    end
                end
            end
            else if (pick < 75)
            begin
                run = $urandom_range(1, 6);
                for (int k = 0; k < run; k++)
                begin
                    add_word(CMD_READ, $urandom, {$urandom, $urandom}, $urandom,
                             (gen_count > 0 && $urandom_range(0, 99) < 85)
                                 ? 7'($urandom_range(0, gen_count - 1)) : 7'($urandom));
                end
            end
            else if (pick < 87)
            begin
                sub = $urandom_range(0, 9);
                if (sub == 0)
                begin
                    thr = '0;
                end
                else if (sub == 1)
                begin
                    thr = '1;
                end
                else if (sub == 2)
                begin
                    thr = $urandom;
                end
                else
                begin
                    thr = gen_frame - 32'($urandom_range(0, 24));
                end
                add_word(CMD_EXPIRE, $urandom, {$urandom, $urandom}, thr, 7'($urandom));
                gen_count = gen_count / 2;
            end
            else if (pick < 91)
            begin
                add_word(CMD_CLEAR, $urandom, {$urandom, $urandom}, $urandom, 7'($urandom));
                gen_count = 0;
                gen_frame = $urandom;
            end
            else
            begin
                add_word(thr_cmd_t'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                         $urandom, 7'($urandom));
            end
        end
        words_total = word_backlog.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken and answered, then let the pipe drain.
        while (words_taken != words_total)
        begin
            @(posedge clk);
        end
        while (owed_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pushes (%0d into a full ring), %0d expires, %0d clears,",
                 n_push, n_push_full, n_expire, n_clear);
        $display("and %0d reads (%0d hits, %0d misses); %0d result words, %0d bad.",
                 n_hit + n_miss, n_hit, n_miss, answers_seen, bad_words);
        if (bad_words == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/thr_pkg.sv
rtl/core/thr_ram.sv
rtl/core/thr_front.sv
rtl/core/thr_back.sv
rtl/core/timestamped_history_ring_core.sv
rtl/core/thr_checker.sv
test/timestamped_history_ring_core_test.sv
